@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// Define NO_ASSERTIONS to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every enabled edge
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants
// Operation codes, cell command struct and size defaults for the LRU cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

   // field widths fixed by the channel definition
   localparam int unsigned FIELD_BITS = 32;
   localparam int unsigned CNT_BITS   = 5;

   // parameter defaults
   localparam int unsigned DEPTH_DEFAULT      = 16;
   localparam int unsigned KEY_BITS_DEFAULT   = 32;
   localparam int unsigned VALUE_BITS_DEFAULT = 32;

   // capacity register value after reset
   localparam logic [CNT_BITS-1:0] CAPACITY_RESET = 5'd16;

   // operation codes
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // command broadcast to every cell
   typedef struct packed {
      logic     en;
      kind_type kind;
   } cell_cmd_type;

endpackage

`default_nettype wire

@@ rtl/lrc_req_if.sv @@
// ----------------------------------------------------------------------------
// lrc_req_if: request channel
// Valid/ready channel carrying one cache operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lrc_req_if import lrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   kind_type              kind;
   logic [FIELD_BITS-1:0] key;
   logic [FIELD_BITS-1:0] value;

   modport source (output valid, kind, key, value, input ready);
   modport sink   (input valid, kind, key, value, output ready);
endinterface

`default_nettype wire

@@ rtl/lrc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lrc_rsp_if: response channel
// Valid/ready channel carrying the result of one cache operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lrc_rsp_if import lrc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [FIELD_BITS-1:0] value_out;
   logic                  evicted;
   logic [FIELD_BITS-1:0] evicted_key;
   logic [FIELD_BITS-1:0] evicted_value;
   logic [CNT_BITS-1:0]   occupancy;

   modport source (output valid, hit, value_out, evicted, evicted_key, evicted_value,
                   occupancy, input ready);
   modport sink   (input valid, hit, value_out, evicted, evicted_key, evicted_value,
                   occupancy, output ready);
endinterface

`default_nettype wire

@@ rtl/lrc_cell.sv @@
// ----------------------------------------------------------------------------
// lrc_cell: one recency slot
// Holds one key/value entry, compares it against the request key and moves
// it toward or away from the front by taking its neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrc_cell import lrc_pkg::*; #(
   parameter int unsigned INDEX      = 0,
   parameter int unsigned KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire cell_cmd_type          cmd,
   input  wire logic [KEY_BITS-1:0]   lookup_key,
   input  wire logic [CNT_BITS-1:0]   count,
   input  wire logic                  found_all,
   // neighbor toward the front (slot INDEX-1) and toward the back (INDEX+1)
   input  wire logic [KEY_BITS-1:0]   prev_key,
   input  wire logic [VALUE_BITS-1:0] prev_value,
   input  wire logic [KEY_BITS-1:0]   next_key,
   input  wire logic [VALUE_BITS-1:0] next_value,
   // chain from the front
   input  wire logic                  found_in,
   input  wire logic [VALUE_BITS-1:0] sel_value_in,
   input  wire logic [KEY_BITS-1:0]   last_key_in,
   input  wire logic [VALUE_BITS-1:0] last_value_in,
   output logic                       found_out,
   output logic [VALUE_BITS-1:0]      sel_value_out,
   output logic [KEY_BITS-1:0]        last_key_out,
   output logic [VALUE_BITS-1:0]      last_value_out,
   // entry held here
   output logic [KEY_BITS-1:0]        key_q,
   output logic [VALUE_BITS-1:0]      value_q,
   output logic                       match
);

   localparam logic [8:0] IDX_L = 9'(INDEX);

   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  occupied;
   logic                  is_last;
   logic                  shift_down;
   logic                  shift_up;

   // slot position relative to the fill count
   assign occupied = 9'(count) > IDX_L;
   assign is_last  = 9'(count) == (IDX_L + 9'd1);

   // key compare and chain outputs
   assign match          = occupied && (key_ff == lookup_key);
   assign found_out      = found_in | match;
   assign sel_value_out  = match ? value_ff : sel_value_in;
   assign last_key_out   = is_last ? key_ff : last_key_in;
   assign last_value_out = is_last ? value_ff : last_value_in;

   // movement decision
   always_comb begin
      shift_down = 1'b0;
      shift_up   = 1'b0;
      case (cmd.kind)
         KIND_INSERT: shift_down = !found_in;
         KIND_LOOKUP: shift_down = found_all && !found_in;
         KIND_REMOVE: shift_up   = found_in || match;
         KIND_CLEAR:  ;
         default:     ;
      endcase
   end

   // next entry
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.en && shift_down) begin
         key_in   = prev_key;
         value_in = prev_value;
      end else if (cmd.en && shift_up) begin
         key_in   = next_key;
         value_in = next_value;
      end
   end

   // entry registers, undefined until written
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_q   = key_ff;
   assign value_q = value_ff;

endmodule

`default_nettype wire

@@ rtl/lru_recency_cache.sv @@
// One result per request; the result register loads at the transfer edge and
// is shown in the cycle after.
// Throughput is one request per cycle while results are taken, set by the key
// compare in every cell and the found chain through the cells in that cycle.
// Reset clears the fill count, loads capacity 16 and empties the result
// register; entry contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// lru_recency_cache: move-to-front LRU key/value cache
// A row of cells holds the entries most recent first; insert, lookup,
// remove and clear are applied to all cells at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lru_recency_cache import lrc_pkg::*; #(
   parameter int unsigned DEPTH      = DEPTH_DEFAULT,
   parameter int unsigned KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int unsigned VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   lrc_req_if.sink                  req_ch,
   lrc_rsp_if.source                rsp_ch,
   input  wire logic                csr_write_enable,
   input  wire logic [CNT_BITS-1:0] csr_write_data
);

   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic [CNT_BITS-1:0]   cap_ff;
   logic [CNT_BITS-1:0]   cap_eff;
   logic                  accept;
   cell_cmd_type          cmd;
   logic [KEY_BITS-1:0]   req_key_w;
   logic [VALUE_BITS-1:0] req_value_w;
   logic [VALUE_BITS-1:0] head_value;
   logic                  found_all;

   logic                  found_w    [DEPTH+1];
   logic [VALUE_BITS-1:0] sel_w      [DEPTH+1];
   logic [KEY_BITS-1:0]   last_key_w [DEPTH+1];
   logic [VALUE_BITS-1:0] last_val_w [DEPTH+1];
   logic [KEY_BITS-1:0]   cell_key   [DEPTH];
   logic [VALUE_BITS-1:0] cell_val   [DEPTH];
   logic [DEPTH-1:0]      match_vec;

   logic                  rsp_valid_ff;
   logic                  hit_ff,     hit_in;
   logic [FIELD_BITS-1:0] vout_ff,    vout_in;
   logic                  ev_ff,      ev_in;
   logic [FIELD_BITS-1:0] ev_key_ff,  ev_key_in;
   logic [FIELD_BITS-1:0] ev_val_ff,  ev_val_in;

   // handshake: the result register frees when its content is taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd.en       = accept;
   assign cmd.kind     = req_ch.kind;
   assign req_key_w    = KEY_BITS'(req_ch.key);
   assign req_value_w  = VALUE_BITS'(req_ch.value);

   // effective capacity, clamped to one and to the cell count
   always_comb begin
      cap_eff = cap_ff;
      if (cap_ff == '0) begin
         cap_eff = CNT_BITS'(1);
      end else if (9'(cap_ff) > 9'(DEPTH)) begin
         cap_eff = CNT_BITS'(DEPTH);
      end
   end

   // chain ends
   assign found_w[0]    = 1'b0;
   assign sel_w[0]      = '0;
   assign last_key_w[0] = '0;
   assign last_val_w[0] = '0;
   assign found_all     = found_w[DEPTH];
   assign head_value    = (req_ch.kind == KIND_INSERT) ? req_value_w : sel_w[DEPTH];

   // row of cells, slot 0 most recent
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0]   p_key;
      logic [VALUE_BITS-1:0] p_val;
      logic [KEY_BITS-1:0]   n_key;
      logic [VALUE_BITS-1:0] n_val;

      if (i == 0) begin : g_head
         assign p_key = req_key_w;
         assign p_val = head_value;
      end else begin : g_mid
         assign p_key = cell_key[i-1];
         assign p_val = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign n_key = cell_key[i];
         assign n_val = cell_val[i];
      end else begin : g_body
         assign n_key = cell_key[i+1];
         assign n_val = cell_val[i+1];
      end

      lrc_cell #(
         .INDEX      (i),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .lookup_key     (req_key_w),
         .count          (count_ff),
         .found_all      (found_all),
         .prev_key       (p_key),
         .prev_value     (p_val),
         .next_key       (n_key),
         .next_value     (n_val),
         .found_in       (found_w[i]),
         .sel_value_in   (sel_w[i]),
         .last_key_in    (last_key_w[i]),
         .last_value_in  (last_val_w[i]),
         .found_out      (found_w[i+1]),
         .sel_value_out  (sel_w[i+1]),
         .last_key_out   (last_key_w[i+1]),
         .last_value_out (last_val_w[i+1]),
         .key_q          (cell_key[i]),
         .value_q        (cell_val[i]),
         .match          (match_vec[i])
      );
   end

   // result and next fill count
   always_comb begin
      count_in  = count_ff;
      hit_in    = 1'b0;
      vout_in   = '0;
      ev_in     = 1'b0;
      ev_key_in = '0;
      ev_val_in = '0;
      case (req_ch.kind)
         KIND_INSERT: begin
            hit_in = found_all;
            if (!found_all) begin
               if (count_ff >= cap_eff) begin
                  ev_in     = 1'b1;
                  ev_key_in = FIELD_BITS'(last_key_w[DEPTH]);
                  ev_val_in = FIELD_BITS'(last_val_w[DEPTH]);
                  count_in  = cap_eff;
               end else begin
                  count_in  = count_ff + CNT_BITS'(1);
               end
            end
         end
         KIND_LOOKUP: begin
            hit_in  = found_all;
            vout_in = FIELD_BITS'(sel_w[DEPTH]);
         end
         KIND_REMOVE: begin
            hit_in = found_all;
            if (found_all) begin
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         KIND_CLEAR: begin
            count_in = '0;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_write_enable && (count_ff == '0)) begin
            cap_ff <= csr_write_data;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff    <= hit_in;
         vout_ff   <= vout_in;
         ev_ff     <= ev_in;
         ev_key_ff <= ev_key_in;
         ev_val_ff <= ev_val_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = hit_ff;
   assign rsp_ch.value_out     = vout_ff;
   assign rsp_ch.evicted       = ev_ff;
   assign rsp_ch.evicted_key   = ev_key_ff;
   assign rsp_ch.evicted_value = ev_val_ff;
   assign rsp_ch.occupancy     = count_ff;

   // checks
   `ASSERT_ALWAYS(a_count_le_cap, clock, reset, count_ff <= cap_eff)
   `ASSERT_ALWAYS(a_unique_match, clock, reset, $onehot0(match_vec))
   `ASSERT_NEXT(a_clear_empties, clock, reset, accept && (req_ch.kind == KIND_CLEAR),
                count_ff == '0)
   `ASSERT_IMPLIES(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_ch.ready,
                   !req_ch.ready)

endmodule

`default_nettype wire

@@ sim/lrc_result_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_result_check: result checker for the LRU recency cache
// Watches request transfers and capacity writes, keeps its own move-to-front
// copy of the cache and compares every result transfer field by field.
// ----------------------------------------------------------------------------

module lrc_result_check import lrc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   lrc_req_if                       req_ch,
   lrc_rsp_if                       rsp_ch,
   input  wire logic                csr_write_enable,
   input  wire logic [CNT_BITS-1:0] csr_write_data,
   output int                       failure_count,
   output int                       outstanding,
   output int                       compared,
   output int                       hit_total,
   output int                       evict_total
);

   localparam int SLOTS = DEPTH_DEFAULT;

   // one result as the cache should report it
   typedef struct packed {
      logic                  hit;
      logic [FIELD_BITS-1:0] value_out;
      logic                  evicted;
      logic [FIELD_BITS-1:0] evicted_key;
      logic [FIELD_BITS-1:0] evicted_value;
      logic [CNT_BITS-1:0]   occupancy;
   } outcome_type;

   // shadow entries, most recent first
   logic [FIELD_BITS-1:0] slot_key   [SLOTS];
   logic [FIELD_BITS-1:0] slot_value [SLOTS];
   int                    fill;
   logic [CNT_BITS-1:0]   capacity_reg;
   outcome_type           awaited [$];

   // capacity as the cache applies it
   function automatic int effective_capacity();
      int c;
      c = int'(capacity_reg);
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
   endfunction

   // slot holding the key, or fill when absent
   function automatic int find_slot(logic [FIELD_BITS-1:0] key);
      for (int i = 0; i < fill; i++)
         if (slot_key[i] == key) return i;
      return fill;
   endfunction

   // open slot 0 by moving slots below upto one place back
   task automatic push_back_slots(int upto);
      for (int i = upto; i > 0; i--) begin
         slot_key[i]   = slot_key[i-1];
         slot_value[i] = slot_value[i-1];
      end
   endtask

   // apply one access to the shadow cache and return its result
   task automatic predict_access(input kind_type kind, input logic [FIELD_BITS-1:0] key,
                                 input logic [FIELD_BITS-1:0] value,
                                 output outcome_type res);
      int cap;
      int idx;
      logic [FIELD_BITS-1:0] found_value;
      res = '0;
      cap = effective_capacity();
      idx = find_slot(key);
      case (kind)
         KIND_INSERT: begin
            if (idx < fill) begin
               res.hit = 1'b1;
               push_back_slots(idx);
            end else if (fill >= cap) begin
               res.evicted       = 1'b1;
               res.evicted_key   = slot_key[fill-1];
               res.evicted_value = slot_value[fill-1];
               fill = cap;
               push_back_slots(cap - 1);
            end else begin
               push_back_slots(fill);
               fill++;
            end
            slot_key[0]   = key;
            slot_value[0] = value;
         end
         KIND_LOOKUP: begin
            if (idx < fill) begin
               found_value   = slot_value[idx];
               res.hit       = 1'b1;
               res.value_out = found_value;
               push_back_slots(idx);
               slot_key[0]   = key;
               slot_value[0] = found_value;
            end
         end
         KIND_REMOVE: begin
            if (idx < fill) begin
               res.hit = 1'b1;
               for (int i = idx; i + 1 < fill; i++) begin
                  slot_key[i]   = slot_key[i+1];
                  slot_value[i] = slot_value[i+1];
               end
               fill--;
            end
         end
         default: fill = 0;
      endcase
      res.occupancy = fill[CNT_BITS-1:0];
   endtask

   // one line per mismatch, printing capped
   task automatic report_mismatch(string what, logic [FIELD_BITS-1:0] got,
                                  logic [FIELD_BITS-1:0] want);
      failure_count++;
      if (failure_count <= 30)
         $display("[%0t] %s: got 0x%08h, want 0x%08h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         fill         = 0;
         capacity_reg = CAPACITY_RESET;
         awaited.delete();
         failure_count = 0;
         compared      = 0;
         hit_total     = 0;
         evict_total   = 0;
      end else begin
         // capacity write only takes effect on an empty cache
         if (csr_write_enable && fill == 0) capacity_reg = csr_write_data;

         // predict on each request transfer
         if (req_ch.valid && req_ch.ready) begin
            predict_access(req_ch.kind, req_ch.key, req_ch.value, want);
            awaited.push_back(want);
            if (want.hit) hit_total++;
            if (want.evicted) evict_total++;
         end

         // compare on each result transfer
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.hit           = rsp_ch.hit;
            got.value_out     = rsp_ch.value_out;
            got.evicted       = rsp_ch.evicted;
            got.evicted_key   = rsp_ch.evicted_key;
            got.evicted_value = rsp_ch.evicted_value;
            got.occupancy     = rsp_ch.occupancy;
            if (awaited.size() == 0) begin
               report_mismatch("result with nothing pending, occupancy",
                               FIELD_BITS'(got.occupancy), '0);
            end else begin
               want = awaited.pop_front();
               compared++;
               if (got.hit !== want.hit)
                  report_mismatch("hit", FIELD_BITS'(got.hit), FIELD_BITS'(want.hit));
               if (got.value_out !== want.value_out)
                  report_mismatch("value_out", got.value_out, want.value_out);
               if (got.evicted !== want.evicted)
                  report_mismatch("evicted", FIELD_BITS'(got.evicted),
                                  FIELD_BITS'(want.evicted));
               if (got.evicted_key !== want.evicted_key)
                  report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
               if (got.evicted_value !== want.evicted_value)
                  report_mismatch("evicted_value", got.evicted_value, want.evicted_value);
               if (got.occupancy !== want.occupancy)
                  report_mismatch("occupancy", FIELD_BITS'(got.occupancy),
                                  FIELD_BITS'(want.occupancy));
            end
         end
      end
      outstanding <= awaited.size();
   end

endmodule

`default_nettype wire

@@ sim/lru_recency_cache_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_recency_cache_tb: testbench top for the LRU recency cache
// Drives directed and random insert/lookup/remove/clear traffic over several
// capacity settings with random stalls on both channels; the result checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module lru_recency_cache_tb;
   import lrc_pkg::*;

   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 4;
   localparam int PHASE_ITEMS  = 145;
   localparam int PHASES       = 8;
   localparam int HOLD_PHASE   = 4;
   localparam int POOL_MAX     = 24;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [CNT_BITS-1:0] csr_write_data;

   int failure_count;
   int outstanding;
   int compared;
   int hit_total;
   int evict_total;
   int items_sent;
   int settings_used;
   bit quiet;
   bit hold_request;

   lrc_req_if req_ch ();
   lrc_rsp_if rsp_ch ();

   lru_recency_cache dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lrc_result_check result_check (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failure_count    (failure_count),
      .outstanding      (outstanding),
      .compared         (compared),
      .hit_total        (hit_total),
      .evict_total      (evict_total)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("lru_recency_cache: mismatch");
      $finish;
   end

   // result side: random ready bursts, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // offer one access and hold it until the transfer
   task automatic send_access(kind_type kind, logic [FIELD_BITS-1:0] key,
                              logic [FIELD_BITS-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.key   <= key;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // random idle burst on the request side
   task automatic maybe_pause();
      if (!quiet && !hold_request && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop offering, wait for every result, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CNT_BITS-1:0] setting);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // random traffic over a key pool sized near the capacity, closed by a clear
   task automatic run_phase(logic [CNT_BITS-1:0] setting, bit with_hold);
      logic [FIELD_BITS-1:0] pool [POOL_MAX];
      int pool_size;
      int roll;
      kind_type kind;
      logic [FIELD_BITS-1:0] key;
      pool_size = (setting == 0) ? 1 : (setting > DEPTH_DEFAULT) ? DEPTH_DEFAULT : setting;
      pool_size = pool_size + $urandom_range(1, 6);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      foreach (pool[i]) pool[i] = $urandom;
      write_capacity(setting);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == PHASE_ITEMS / 3) hold_request = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 45) kind = KIND_INSERT;
         else if (roll < 75) kind = KIND_LOOKUP;
         else if (roll < 97) kind = KIND_REMOVE;
         else kind = KIND_CLEAR;
         if ($urandom_range(0, 9) < 8) key = pool[$urandom_range(0, pool_size - 1)];
         else key = $urandom;
         send_access(kind, key, $urandom);
         maybe_pause();
      end
      send_access(KIND_CLEAR, $urandom, $urandom);
      settle();
   endtask

   // stimulus
   initial begin
      logic [CNT_BITS-1:0] settings [PHASES];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_INSERT;
      req_ch.key       = '0;
      req_ch.value     = '0;
      quiet            = 1'b0;
      hold_request     = 1'b0;
      items_sent       = 0;
      settings_used    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty cache at reset capacity: misses, clear, replace, extremes
      send_access(KIND_LOOKUP, 32'h0000_0000, 32'h0);
      send_access(KIND_REMOVE, 32'h0000_0000, 32'h0);
      send_access(KIND_CLEAR, 32'h0000_0000, 32'h0);
      send_access(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_access(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(KIND_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
      send_access(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_access(KIND_LOOKUP, 32'h1234_5678, 32'h0);
      send_access(KIND_REMOVE, 32'h0000_0000, 32'h0);
      send_access(KIND_REMOVE, 32'h0000_0000, 32'h0);
      send_access(KIND_CLEAR, 32'h0000_0000, 32'h0);
      settle();

      // capacity two: eviction, move to front, replace when full
      write_capacity(5'd2);
      send_access(KIND_INSERT, 32'd1, 32'd11);
      send_access(KIND_INSERT, 32'd2, 32'd22);
      send_access(KIND_INSERT, 32'd3, 32'd33);
      send_access(KIND_LOOKUP, 32'd2, 32'h0);
      send_access(KIND_INSERT, 32'd4, 32'd44);
      send_access(KIND_INSERT, 32'd2, 32'd222);
      settle();

      // capacity write on a non-empty cache is dropped
      write_capacity(5'd5);
      send_access(KIND_INSERT, 32'd5, 32'd55);
      send_access(KIND_CLEAR, 32'h0, 32'h0);
      settle();

      // capacity zero behaves as one
      write_capacity(5'd0);
      send_access(KIND_INSERT, 32'd7, 32'd77);
      send_access(KIND_INSERT, 32'd8, 32'd88);
      send_access(KIND_LOOKUP, 32'd7, 32'h0);
      send_access(KIND_CLEAR, 32'h0, 32'h0);
      settle();

      // random phases over several capacities, extremes included
      settings = '{5'd31, 5'd1, 5'd17, CNT_BITS'($urandom_range(2, 15)), 5'd16, 5'd3,
                   CNT_BITS'($urandom_range(1, 16)), 5'd8};
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) quiet = 1'b1;
         run_phase(settings[p], p == HOLD_PHASE);
      end

      settle();
      $display("covered %0d accesses over %0d capacity writes: %0d hits, %0d evictions",
               items_sent, settings_used, hit_total, evict_total);
      $display("%0d results compared, incl. a %0d-cycle result hold-off and an idle-free run",
               compared, HOLD_CYCLES);
      if (failure_count == 0 && outstanding == 0) begin
         $display("lru_recency_cache: match");
      end else begin
         $display("lru_recency_cache: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
